// File: sv/alt_pkg.sv
// Shared types, character codes and escape mapping for the assembler line tokenizer.
// No dependencies.
`default_nettype none

package alt_pkg;

  localparam int BYTE_W     = 8;
  localparam int KIND_W     = 2;
  localparam int QUEUE_DEPTH = 4;

  // line phase
  typedef enum logic [1:0] {
    PH_WAIT  = 2'd0,
    PH_TOKEN = 2'd1,
    PH_RUN   = 2'd2,
    PH_NOTE  = 2'd3
  } phase_e;

  // result kinds
  typedef enum logic [KIND_W-1:0] {
    EV_CHAR     = 2'd0,
    EV_TOK_END  = 2'd1,
    EV_LINE_END = 2'd2
  } event_kind_e;

  // quote mode codes
  localparam logic [1:0] QM_NONE   = 2'd0;
  localparam logic [1:0] QM_SINGLE = 2'd1;
  localparam logic [1:0] QM_DOUBLE = 2'd2;

  localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [BYTE_W-1:0] CH_TAB    = 8'h09;
  localparam logic [BYTE_W-1:0] CH_NL     = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_COMMA  = 8'h2C;
  localparam logic [BYTE_W-1:0] CH_SEMI   = 8'h3B;
  localparam logic [BYTE_W-1:0] CH_SQUOTE = 8'h27;
  localparam logic [BYTE_W-1:0] CH_DQUOTE = 8'h22;
  localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;

  // One accepted byte's results. When two is set, a line end follows the first event.
  typedef struct packed {
    event_kind_e             kind;
    logic [BYTE_W-1:0]       ch;
    logic                    two;
  } bundle_t;

  function automatic logic [BYTE_W-1:0] map_escape(input logic [BYTE_W-1:0] c);
    logic [BYTE_W-1:0] r;
    case (c)
      8'h30:   r = 8'h7F;  // '0'
      8'h61:   r = 8'h07;  // 'a'
      8'h62:   r = 8'h08;  // 'b'
      8'h74:   r = 8'h09;  // 't'
      8'h6E:   r = 8'h0A;  // 'n'
      8'h76:   r = 8'h0B;  // 'v'
      8'h66:   r = 8'h0C;  // 'f'
      8'h72:   r = 8'h0D;  // 'r'
      default: r = c;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// File: sv/alt_in_if.sv
// Input channel: one source text byte per transfer.
// Depends on alt_pkg.
`default_nettype none

interface alt_in_if;
  import alt_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] text_byte;

  modport source (output valid, output text_byte, input ready);
  modport sink   (input valid, input text_byte, output ready);
endinterface

`default_nettype wire

// File: sv/alt_out_if.sv
// Output channel: one token event per transfer.
// Depends on alt_pkg.
`default_nettype none

interface alt_out_if;
  import alt_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] event_kind;
  logic [BYTE_W-1:0] char_value;
  logic              run_last;

  modport source (output valid, output event_kind, output char_value, output run_last,
                  input ready);
  modport sink   (input valid, input event_kind, input char_value, input run_last,
                  output ready);
endinterface

`default_nettype wire

// File: sv/assembler_line_tokenizer.sv
// Assembler line tokenizer: byte stream in, token/line events out.
// Path: each accepted byte's bundle is written into the queue, then loaded into the output register.
// Throughput: one byte per cycle while the queue has room; a line end closing a token or comma run
// gives two events from one bundle; the bundle queue absorbs this, input stalls only when full.
// Reset: quote, escape and line state cleared, queue and output register emptied.
`default_nettype none

module assembler_line_tokenizer #(
  parameter int QueueDepth = alt_pkg::QUEUE_DEPTH
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  alt_in_if.sink    in_ch,
  alt_out_if.source out_ch
);
  import alt_pkg::*;

  logic    push, pop, full, empty;
  bundle_t wr_bundle, rd_bundle;

  alt_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_ch    (in_ch),
    .full_i   (full),
    .push_o   (push),
    .bundle_o (wr_bundle)
  );

  alt_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .wr_data_i (wr_bundle),
    .pop_i     (pop),
    .rd_data_o (rd_bundle),
    .full_o    (full),
    .empty_o   (empty)
  );

  alt_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_data_i (rd_bundle),
    .empty_i   (empty),
    .pop_o     (pop),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire

// File: sv/alt_front.sv
// Front end: accepts bytes, tracks quote/line state, pushes event bundles.
// Depends on alt_pkg and alt_in_if.
`default_nettype none

module alt_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  alt_in_if.sink                in_ch,
  input  wire logic             full_i,
  output logic                  push_o,
  output alt_pkg::bundle_t      bundle_o
);
  import alt_pkg::*;

  logic [1:0] qm_q, qm_d;
  logic       esc_q, esc_d;
  phase_e     ph_q, ph_d;
  logic       rc_q, rc_d;

  logic              accept;
  logic [BYTE_W-1:0] c;
  logic              nl, blank, sep;
  logic              emit;
  bundle_t           bnd;

  assign in_ch.ready = !full_i;
  assign accept      = in_ch.valid && !full_i;
  assign c           = in_ch.text_byte;
  assign nl          = (c == CH_NL);
  assign blank       = (c == CH_SPACE) || (c == CH_TAB) || nl;
  assign sep         = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_COMMA);

  always_comb begin
    logic do_tok;
    logic do_end;
    phase_e end_next;
    qm_d     = qm_q;
    esc_d    = esc_q;
    ph_d     = ph_q;
    rc_d     = rc_q;
    emit     = 1'b0;
    bnd.kind = EV_CHAR;
    bnd.ch   = '0;
    bnd.two  = 1'b0;
    do_tok   = 1'b0;
    do_end   = 1'b0;
    end_next = PH_WAIT;

    if (esc_q) begin
      esc_d  = 1'b0;
      ph_d   = PH_TOKEN;
      rc_d   = 1'b0;
      emit   = 1'b1;
      bnd.ch = map_escape(c);
    end else if (ph_q == PH_NOTE) begin
      if (nl) ph_d = PH_WAIT;
    end else if (qm_q == QM_NONE) begin
      if (ph_q == PH_WAIT) begin
        if (blank) begin
          // skipped before line start
        end else if (c == CH_SEMI) begin
          ph_d = PH_NOTE;
        end else if (c == CH_COMMA) begin
          emit     = 1'b1;
          bnd.kind = EV_TOK_END;
          ph_d     = PH_RUN;
          rc_d     = 1'b1;
        end else begin
          do_tok = 1'b1;
        end
      end else if (nl) begin
        do_end = 1'b1;
      end else if (c == CH_SEMI) begin
        do_end   = 1'b1;
        end_next = PH_NOTE;
      end else if (sep) begin
        if (ph_q == PH_TOKEN) begin
          emit     = 1'b1;
          bnd.kind = EV_TOK_END;
          ph_d     = PH_RUN;
          rc_d     = (c == CH_COMMA);
        end else if (c == CH_COMMA) begin
          rc_d = 1'b1;
        end
      end else begin
        do_tok = 1'b1;
      end
    end else begin
      if (ph_q == PH_WAIT) begin
        do_tok = !blank;
      end else if (nl) begin
        do_end = 1'b1;
      end else begin
        do_tok = 1'b1;
      end
    end

    if (do_tok) begin
      if (c == CH_SQUOTE && qm_q != QM_DOUBLE) begin
        qm_d = (qm_q != QM_NONE) ? QM_NONE : QM_SINGLE;
      end else if (c == CH_DQUOTE && qm_q != QM_SINGLE) begin
        qm_d = (qm_q != QM_NONE) ? QM_NONE : QM_DOUBLE;
      end
      ph_d = PH_TOKEN;
      rc_d = 1'b0;
      if (qm_d != QM_NONE && c == CH_BSLASH) begin
        esc_d = 1'b1;
      end else begin
        emit   = 1'b1;
        bnd.ch = c;
      end
    end

    if (do_end) begin
      emit = 1'b1;
      // open token or comma run closes with an extra token end
      if (ph_q == PH_TOKEN || (ph_q == PH_RUN && rc_q)) begin
        bnd.kind = EV_TOK_END;
        bnd.two  = 1'b1;
      end else begin
        bnd.kind = EV_LINE_END;
      end
      rc_d = 1'b0;
      ph_d = end_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qm_q  <= QM_NONE;
      esc_q <= 1'b0;
      ph_q  <= PH_WAIT;
      rc_q  <= 1'b0;
    end else if (accept) begin
      qm_q  <= qm_d;
      esc_q <= esc_d;
      ph_q  <= ph_d;
      rc_q  <= rc_d;
    end
  end

  assign push_o   = accept && emit;
  assign bundle_o = bnd;

`ifndef SYNTHESIS
  a_esc_in_quotes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    esc_q |-> (qm_q != QM_NONE))
    else $error("escape pending outside quotes");
  a_comma_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rc_q |-> (ph_q == PH_RUN))
    else $error("comma flag set outside separator run");
  a_two_is_tokend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && bundle_o.two) |-> (bundle_o.kind == EV_TOK_END))
    else $error("double bundle without token end");
`endif

endmodule

`default_nettype wire

// File: sv/alt_queue.sv
// Small flop-based FIFO of event bundles between front and back end.
// Depends on alt_pkg.
`default_nettype none

module alt_queue #(
  parameter int Depth = alt_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  alt_pkg::bundle_t      wr_data_i,
  input  wire logic             pop_i,
  output alt_pkg::bundle_t      rd_data_o,
  output logic                  full_o,
  output logic                  empty_o
);
  import alt_pkg::*;

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);

  bundle_t         mem_q [Depth];
  logic [AW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]   cnt_q;
  logic            do_push, do_pop;

  assign full_o    = (cnt_q == CW'(Depth));
  assign empty_o   = (cnt_q == '0);
  assign do_push   = push_i && !full_o;
  assign do_pop    = pop_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= (wr_ptr_q == AW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= (rd_ptr_q == AW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      if (do_push && !do_pop)      cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= wr_data_i;
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("push into full queue");
`endif

endmodule

`default_nettype wire

// File: sv/alt_back.sv
// Back end: pops bundles and drives one event per transfer from an output register.
// Depends on alt_pkg and alt_out_if.
`default_nettype none

module alt_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  alt_pkg::bundle_t      rd_data_i,
  input  wire logic             empty_i,
  output logic                  pop_o,
  alt_out_if.source             out_ch
);
  import alt_pkg::*;

  logic              vld_q, vld_d;
  logic              sec_q, sec_d;   // line end still owed for current bundle
  event_kind_e       kind_q, kind_d;
  logic [BYTE_W-1:0] ch_q, ch_d;
  logic              last_q, last_d;
  logic              load;

  assign load = !vld_q || out_ch.ready;

  always_comb begin
    vld_d  = vld_q;
    sec_d  = sec_q;
    kind_d = kind_q;
    ch_d   = ch_q;
    last_d = last_q;
    pop_o  = 1'b0;
    if (load) begin
      if (sec_q) begin
        vld_d  = 1'b1;
        sec_d  = 1'b0;
        kind_d = EV_LINE_END;
        ch_d   = '0;
        last_d = 1'b1;
      end else if (!empty_i) begin
        pop_o  = 1'b1;
        vld_d  = 1'b1;
        sec_d  = rd_data_i.two;
        kind_d = rd_data_i.kind;
        ch_d   = rd_data_i.ch;
        last_d = !rd_data_i.two;
      end else begin
        vld_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      sec_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
      sec_q <= sec_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    ch_q   <= ch_d;
    last_q <= last_d;
  end

  assign out_ch.valid      = vld_q;
  assign out_ch.event_kind = kind_q;
  assign out_ch.char_value = ch_q;
  assign out_ch.run_last   = last_q;

`ifndef SYNTHESIS
  a_second_follows_tokend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sec_q |-> (vld_q && kind_q == EV_TOK_END && !last_q))
    else $error("owed line end without pending token end");
`endif

endmodule

`default_nettype wire
